### src/dlbfs_pkg.sv
// Shared types, codes and a helper function for the depth-limited BFS engine.
`default_nettype none
package dlbfs_pkg;

  localparam int NODE_MAX    = 64;
  localparam int NODE_W      = 6;
  localparam int TOTN_W      = 7;
  localparam int EDGE_W      = 12;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_RUN,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ADD,
    BK_GATHER,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] visit_order;
    logic [NODE_W-1:0] depth;
    logic [NODE_W-1:0] node;
    logic              last;
    logic [TOTN_W-1:0] node_total;
    logic [EDGE_W-1:0] total_edges;
  } out_item_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
  } cmd_entry_t;

  // Index of the lowest set bit, built from the isolated low bit with no priority chain.
  function automatic logic [NODE_W-1:0] lowest_index(input logic [NODE_MAX-1:0] v);
    logic [NODE_MAX-1:0] low;
    logic [NODE_W-1:0]   idx;
    low = v & (~v + 1'b1);
    for (int k = 0; k < NODE_W; k++) begin
      idx[k] = 1'b0;
      for (int j = 0; j < NODE_MAX; j++) begin
        if (((j >> k) & 1) != 0) begin
          idx[k] = idx[k] | low[j];
        end
      end
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

### src/depth_limited_bfs_engine.sv
// Top level of the depth-limited BFS engine: configuration registers, front, queue and back.
// Inputs are taken one per cycle unless the four-entry queue is full; the back end pops one
// command at a time. An edge add occupies the back end for a row read, then a write; a clear
// is done in the idle state. A run reads each level's frontier rows one per cycle, then emits one
// result per cycle unless out_ready stalls; the row memory's single read port sets the gather pace.
// Reset is synchronous and empties the graph at once through per-row valid bits, with no sweep.
`default_nettype none
module depth_limited_bfs_engine
  import dlbfs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_MAX
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [NODE_W-1:0]    cfg_data
);

  logic [NODE_W-1:0] root_node;
  logic [NODE_W-1:0] depth_limit;
  logic              q_full;
  logic              q_push;
  cmd_entry_t        q_push_entry;
  logic              q_pop;
  logic              q_valid;
  cmd_entry_t        q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node   <= '0;
      depth_limit <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROOT:  root_node   <= cfg_data;
        CFG_LIMIT: depth_limit <= cfg_data;
        default:   root_node   <= root_node;
      endcase
    end
  end

  dlbfs_front #(
    .NODE_COUNT(NODE_COUNT)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_push_entry)
  );

  dlbfs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  dlbfs_back #(
    .NODE_COUNT(NODE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .root_node   (root_node),
    .depth_limit (depth_limit),
    .q_valid     (q_valid),
    .q_entry     (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

### src/dlbfs_front.sv
// Front end: accepts input items and turns the meaningful ones into queue commands.
`default_nettype none
module dlbfs_front
  import dlbfs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_MAX
) (
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_item,
  input  wire logic       q_full,
  output logic            q_push,
  output cmd_entry_t      q_entry
);

  logic keep;
  logic src_ok;
  logic dst_ok;

  assign src_ok = TOTN_W'(in_item.src_node) < TOTN_W'(NODE_COUNT);
  assign dst_ok = TOTN_W'(in_item.dst_node) < TOTN_W'(NODE_COUNT);

  always_comb begin
    keep        = 1'b0;
    q_entry.cmd = CMD_ADD;
    q_entry.src = in_item.src_node;
    q_entry.dst = in_item.dst_node;
    unique case (in_item.action)
      ACT_ADD: begin
        keep        = src_ok && dst_ok && (in_item.src_node != in_item.dst_node);
        q_entry.cmd = CMD_ADD;
      end
      ACT_RUN: begin
        keep        = 1'b1;
        q_entry.cmd = CMD_RUN;
      end
      ACT_CLEAR: begin
        keep        = 1'b1;
        q_entry.cmd = CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule
`default_nettype wire

### src/dlbfs_queue.sv
// Short command queue between the front end and the search back end.
`default_nettype none
module dlbfs_queue
  import dlbfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire cmd_entry_t push_entry,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output cmd_entry_t      head_entry
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_entry_t       entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/dlbfs_back.sv
// Back end: adjacency memory, graph counts, level-by-level search and result register.
`default_nettype none
module dlbfs_back
  import dlbfs_pkg::*;
#(
  parameter int NODE_COUNT = NODE_MAX
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [NODE_W-1:0] root_node,
  input  wire logic [NODE_W-1:0] depth_limit,
  input  wire logic              q_valid,
  input  wire cmd_entry_t        q_entry,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_item
);

  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  typedef logic [NODE_COUNT-1:0] row_t;

  function automatic row_t hot_of(input logic [ADDR_W-1:0] a);
    return row_t'(1) << a;
  endfunction

  row_t              row_mem [NODE_COUNT];
  row_t              row_valid;
  row_t              rd_data;
  logic              rd_ok;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  row_t              wr_data;
  logic              clear_all;
  row_t              row_word;

  back_state_t       state, state_next;
  row_t              frontier, frontier_next;
  row_t              visited, visited_next;
  row_t              gather_left, gather_left_next;
  row_t              next_acc, next_acc_next;
  row_t              emit_left, emit_left_next;
  row_t              nxt_front, nxt_front_next;
  logic [NODE_W-1:0] level, level_next;
  logic [NODE_W-1:0] order, order_next;
  logic [TOTN_W-1:0] totn, totn_next;
  logic              rd_pend, rd_pend_next;
  logic [ADDR_W-1:0] add_src, add_src_next;
  logic [ADDR_W-1:0] add_dst, add_dst_next;
  row_t              node_seen, node_seen_next;
  logic [TOTN_W-1:0] node_count, node_count_next;
  logic [EDGE_W-1:0] edge_count, edge_count_next;
  logic              out_load;
  out_item_t         out_new;

  logic              stop;
  logic              final_level;
  logic [NODE_W-1:0] pick;
  logic [ADDR_W-1:0] pick_a;
  logic [ADDR_W-1:0] src_a;
  row_t              rest;
  row_t              bit_hot;

  assign row_word    = rd_ok ? rd_data : '0;
  assign stop        = (depth_limit != '0) && (level >= depth_limit);
  assign final_level = stop || (nxt_front == '0);
  assign src_a       = root_node[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= row_mem[rd_addr];
      rd_ok   <= row_valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      node_seen  <= '0;
      node_count <= '0;
      edge_count <= '0;
      out_valid  <= 1'b0;
      rd_pend    <= 1'b0;
    end else begin
      state      <= state_next;
      node_seen  <= node_seen_next;
      node_count <= node_count_next;
      edge_count <= edge_count_next;
      rd_pend    <= rd_pend_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    frontier    <= frontier_next;
    visited     <= visited_next;
    gather_left <= gather_left_next;
    next_acc    <= next_acc_next;
    emit_left   <= emit_left_next;
    nxt_front   <= nxt_front_next;
    level       <= level_next;
    order       <= order_next;
    totn        <= totn_next;
    add_src     <= add_src_next;
    add_dst     <= add_dst_next;
    if (out_load) begin
      out_item <= out_new;
    end
  end

  always_comb begin
    state_next       = state;
    frontier_next    = frontier;
    visited_next     = visited;
    gather_left_next = gather_left;
    next_acc_next    = next_acc;
    emit_left_next   = emit_left;
    nxt_front_next   = nxt_front;
    level_next       = level;
    order_next       = order;
    totn_next        = totn;
    rd_pend_next     = 1'b0;
    add_src_next     = add_src;
    add_dst_next     = add_dst;
    node_seen_next   = node_seen;
    node_count_next  = node_count;
    edge_count_next  = edge_count;
    q_pop            = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = '0;
    wr_en            = 1'b0;
    wr_addr          = add_src;
    wr_data          = '0;
    clear_all        = 1'b0;
    out_load         = 1'b0;
    out_new          = '0;
    pick             = '0;
    pick_a           = '0;
    rest             = '0;
    bit_hot          = hot_of(add_dst);
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_entry.cmd)
            CMD_ADD: begin
              rd_en        = 1'b1;
              rd_addr      = q_entry.src[ADDR_W-1:0];
              add_src_next = q_entry.src[ADDR_W-1:0];
              add_dst_next = q_entry.dst[ADDR_W-1:0];
              state_next   = BK_ADD;
            end
            CMD_RUN: begin
              if (TOTN_W'(root_node) < TOTN_W'(NODE_COUNT)) begin
                frontier_next    = hot_of(src_a);
                visited_next     = hot_of(src_a);
                gather_left_next = hot_of(src_a);
                next_acc_next    = '0;
                level_next       = '0;
                order_next       = '0;
                totn_next        = node_count + {{(TOTN_W-1){1'b0}}, ~node_seen[src_a]};
                state_next       = BK_GATHER;
              end
            end
            CMD_CLEAR: begin
              clear_all       = 1'b1;
              node_seen_next  = '0;
              node_count_next = '0;
              edge_count_next = '0;
            end
            default: begin
              clear_all = 1'b0;
            end
          endcase
        end
      end
      BK_ADD: begin
        if ((row_word & bit_hot) == '0) begin
          wr_en           = 1'b1;
          wr_data         = row_word | bit_hot;
          edge_count_next = edge_count + 1'b1;
        end
        node_seen_next  = node_seen | hot_of(add_src) | bit_hot;
        node_count_next = node_count + {{(TOTN_W-1){1'b0}}, ~node_seen[add_src]}
                        + {{(TOTN_W-1){1'b0}}, ~node_seen[add_dst]};
        state_next      = BK_IDLE;
      end
      BK_GATHER: begin
        if (rd_pend) begin
          next_acc_next = next_acc | row_word;
        end
        if (stop) begin
          nxt_front_next = '0;
          emit_left_next = frontier;
          state_next     = BK_EMIT;
        end else if (gather_left != '0) begin
          pick             = lowest_index(NODE_MAX'(gather_left));
          pick_a           = pick[ADDR_W-1:0];
          rd_en            = 1'b1;
          rd_addr          = pick_a;
          rd_pend_next     = 1'b1;
          gather_left_next = gather_left & ~hot_of(pick_a);
        end else if (!rd_pend) begin
          nxt_front_next = next_acc & ~visited;
          emit_left_next = frontier;
          state_next     = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (!out_valid || out_ready) begin
          pick                = lowest_index(NODE_MAX'(emit_left));
          pick_a              = pick[ADDR_W-1:0];
          rest                = emit_left & ~hot_of(pick_a);
          out_load            = 1'b1;
          out_new.visit_order = order;
          out_new.depth       = level;
          out_new.node        = pick;
          out_new.last        = final_level && (rest == '0);
          out_new.node_total  = totn;
          out_new.total_edges = edge_count;
          order_next          = order + 1'b1;
          emit_left_next      = rest;
          if (rest == '0) begin
            if (final_level) begin
              state_next = BK_IDLE;
            end else begin
              frontier_next    = nxt_front;
              visited_next     = visited | nxt_front;
              gather_left_next = nxt_front;
              next_acc_next    = '0;
              level_next       = level + 1'b1;
              state_next       = BK_GATHER;
            end
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### src/dlbfs_checker.sv
// Port-level checker for the depth-limited BFS engine and its bind to the top level.
`default_nettype none
module dlbfs_checker
  import dlbfs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid right after reset.");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result changed or dropped.");

  a_depth_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_item.depth <= out_item.visit_order)
    else $error("Depth exceeds the visit order.");

  a_order_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, out_item.visit_order} < out_item.node_total)
    else $error("Visit order not below the node count.");

endmodule

bind depth_limited_bfs_engine dlbfs_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
